### rtl/core/mca_pkg.sv
// shared types and constants of the majority cellular automaton
package mca_pkg;

	localparam int MAX_CELLS = 64;
	localparam int ADDR_W    = $clog2(MAX_CELLS);
	localparam int NW        = $clog2(MAX_CELLS + 1);
	localparam int CNT_W     = $clog2(MAX_CELLS + 6);

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_BORDER_MODE  = 2'd0,
		CFG_BORDER_VALUE = 2'd1,
		CFG_LATTICE_SIZE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		SRC_MEM,
		SRC_BORDER,
		SRC_HEAD
	} src_t;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] cell_index;
		logic       cell_value;
	} cmd_req_t;

	typedef struct packed {
		logic read_value;
		logic index_error;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic              wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

### rtl/core/majority_cellular_automaton_1d.sv
// one-dimensional majority cellular automaton, top level
// Usage: requests arrive on cmd (cmd_valid / cmd_stall) and each one gives
// exactly one response on rsp (rsp_valid / rsp_stall). A write or an
// out-of-range access answers in the cycle after acceptance; another request
// may follow in the next cycle; a read answers from ST_READ, as the cell
// store has a registered read port. A generation step sweeps the store one
// cell per cycle through a seven-cell window, reading each position in turn
// (the last three twice when the border wraps) and writing the new state back
// three positions behind; it answers once the last write has drained.
// Only one request is worked on at a time; cmd_stall is high while a read or
// a sweep is under way. The response register lets a new request be taken
// while the previous response waits; when rsp_stall holds it, cmd_stall
// stays high until the response is taken. Configuration goes through
// cfg_valid / cfg_ready (always ready); the user must write it only while the
// block is idle, which the block does not check. Reset clears every cell, sets
// an open border of value 0, a lattice size of 64, and empties both channels.
module majority_cellular_automaton_1d
	import mca_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  cmd_req_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rsp_t     rsp,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	state_t            state_q, state_d;
	logic              mode_q, bval_q;
	logic [6:0]        lat_q;
	logic [NW-1:0]     used_n;
	logic              accept, idx_err;
	logic              rvalid_q, rsp_load;
	rsp_t              rsp_q, rsp_d;
	logic              sweep_start, issue;
	logic              wr_cmd;
	logic [CNT_W-1:0]  k_q;
	logic [ADDR_W-1:0] ptr_q, ptr_start, ptr_last;
	logic              k_low, k_beyond, k_last;
	src_t              src_issue;
	logic              sv_s1;
	src_t              src_s1;
	logic [CNT_W-1:0]  k_s1;
	logic [ADDR_W-1:0] ptr_s1;
	logic              head_q [3];
	logic              head_v, v_s1, maj;
	logic [5:0]        win_q;
	logic [2:0]        ones;
	logic              wr_en_s2, wr_data_s2;
	logic [ADDR_W-1:0] wr_addr_s2;
	mem_req_t          mreq;
	logic              rd_bit;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			bval_q <= 1'b0;
			lat_q  <= 7'd64;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BORDER_MODE:  mode_q <= cfg_data[0];
				CFG_BORDER_VALUE: bval_q <= cfg_data[0];
				CFG_LATTICE_SIZE: lat_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign used_n = (32'(lat_q) > MAX_CELLS) ? NW'(MAX_CELLS) : NW'(lat_q);

	// request side
	assign cmd_stall = !((state_q == ST_IDLE) && (!rvalid_q || !rsp_stall));
	assign accept    = cmd_valid && !cmd_stall;
	assign idx_err   = NW'(cmd.cell_index) >= used_n;

	// sweep position: window step j = k - 3, read position j modulo n
	assign ptr_last  = ADDR_W'(used_n - NW'(1));
	assign ptr_start = (used_n >= NW'(3)) ? ADDR_W'(used_n - NW'(3)) :
	                   (used_n == NW'(2)) ? ADDR_W'(1) : '0;
	assign k_low     = k_q < CNT_W'(3);
	assign k_beyond  = k_q >= (CNT_W'(used_n) + CNT_W'(3));
	assign k_last    = k_q == (CNT_W'(used_n) + CNT_W'(5));

	always_comb begin
		if (k_beyond) begin
			src_issue = mode_q ? SRC_HEAD : SRC_BORDER;
		end else if (k_low) begin
			src_issue = mode_q ? SRC_MEM : SRC_BORDER;
		end else begin
			src_issue = SRC_MEM;
		end
	end

	// next state and outputs
	always_comb begin
		state_d     = state_q;
		rsp_load    = 1'b0;
		rsp_d       = '0;
		sweep_start = 1'b0;
		issue       = 1'b0;
		wr_cmd      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(cmd.command))
						CMD_WRITE: begin
							rsp_load          = 1'b1;
							rsp_d.index_error = idx_err;
							rsp_d.read_value  = !idx_err && cmd.cell_value;
							wr_cmd            = !idx_err;
						end
						CMD_READ: begin
							if (idx_err) begin
								rsp_load          = 1'b1;
								rsp_d.index_error = 1'b1;
							end else begin
								state_d = ST_READ;
							end
						end
						CMD_STEP: begin
							if (used_n == '0) begin
								rsp_load = 1'b1;
							end else begin
								sweep_start = 1'b1;
								state_d     = ST_SWEEP;
							end
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				rsp_load         = 1'b1;
				rsp_d.read_value = rd_bit;
				state_d          = ST_IDLE;
			end
			ST_SWEEP: begin
				issue = 1'b1;
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sv_s1 && !wr_en_s2) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rvalid_q <= 1'b1;
			end else if (rvalid_q && !rsp_stall) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rvalid_q;
	assign rsp       = rsp_q;

	// sweep issue counters
	always_ff @(posedge clk) begin
		if (sweep_start) begin
			k_q   <= '0;
			ptr_q <= ptr_start;
		end else if (issue) begin
			k_q   <= k_q + CNT_W'(1);
			ptr_q <= (ptr_q == ptr_last) ? '0 : ptr_q + ADDR_W'(1);
		end
	end

	// read data stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s1 <= 1'b0;
		end else begin
			sv_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		src_s1 <= src_issue;
		k_s1   <= k_q;
		ptr_s1 <= ptr_q;
	end

	// wrapped reads past the end see the first three cells as they were
	always_comb begin
		case (ptr_s1[1:0])
			2'd0:    head_v = head_q[0];
			2'd1:    head_v = head_q[1];
			default: head_v = head_q[2];
		endcase
	end

	always_comb begin
		case (src_s1)
			SRC_MEM:    v_s1 = rd_bit;
			SRC_BORDER: v_s1 = bval_q;
			SRC_HEAD:   v_s1 = head_v;
			default:    v_s1 = 1'b0;
		endcase
	end

	// window: win_q[0] is p+2 ... win_q[5] is p-3, v_s1 is p+3
	assign ones = 3'(win_q[0]) + 3'(win_q[2]) + 3'(win_q[4]) + 3'(win_q[5]) + 3'(v_s1);
	assign maj  = ones >= 3'd3;

	always_ff @(posedge clk) begin
		if (sv_s1) begin
			win_q <= {win_q[4:0], v_s1};
			if (src_s1 == SRC_MEM && k_s1 >= CNT_W'(3) && k_s1 < CNT_W'(6)) begin
				head_q[2'(k_s1 - CNT_W'(3))] <= v_s1;
			end
		end
		wr_addr_s2 <= ADDR_W'(k_s1 - CNT_W'(6));
		wr_data_s2 <= maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s2 <= 1'b0;
		end else begin
			wr_en_s2 <= sv_s1 && (k_s1 >= CNT_W'(6));
		end
	end

	// store port
	always_comb begin
		mreq.we    = wr_en_s2 || wr_cmd;
		mreq.waddr = wr_en_s2 ? wr_addr_s2 : ADDR_W'(cmd.cell_index);
		mreq.wdata = wr_en_s2 ? wr_data_s2 : cmd.cell_value;
		mreq.raddr = (state_q == ST_SWEEP) ? ptr_q : ADDR_W'(cmd.cell_index);
	end

	mca_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rd_bit (rd_bit)
	);

endmodule

### rtl/core/mca_store.sv
// cell store: one-bit memory with per-entry valid bits cleared at reset
module mca_store
	import mca_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output logic     rd_bit
);

	logic                 mem [MAX_CELLS];
	logic                 rdata_q;
	logic [MAX_CELLS-1:0] vld_q;
	logic                 vld_rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= vld_q[req.raddr];
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
		end
	end

	// an entry never written reads as dead
	assign rd_bit = rdata_q & vld_rd_q;

endmodule
